[hdl/abt_pkg.sv]
package abt_pkg;

  // Table geometry and field widths.
  localparam int TABLE_BITS = 16;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = COUNT_W + 1;
  localparam int PROB_W     = 12;
  localparam int NUM_W      = COUNT_W + PROB_W;

  // Stream payload widths, rounded up to whole bytes.
  localparam int CTX_W      = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // The divider retires three quotient bits per cycle.
  localparam int DIV_BITS_PER_STEP = 3;
  localparam int DIV_STEPS         = PROB_W / DIV_BITS_PER_STEP;
  localparam int STEP_W            = $clog2(DIV_STEPS);

  localparam logic [PROB_W-1:0]  PROB_SCALE  = 12'd4095;
  localparam logic [PROB_W-1:0]  PROB_MIN    = 12'd1;
  localparam logic [PROB_W-1:0]  PROB_MAX    = 12'd4094;
  localparam logic [PROB_W-1:0]  PROB_MID    = 12'd2048;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE   = 16'd1;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd1023;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_LEARN   = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] one_count;
    logic [COUNT_W-1:0] zero_count;
  } entry_t;

  // Handshake between the controller and the divider.
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [SUM_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PROB_W-1:0]  quot;
  } div_rsp_t;

endpackage

[hdl/abt_ram.sv]
module abt_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/abt_div.sv]
module abt_div import abt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // Restoring division. The quotient is known to fit in PROB_W bits, so the
  // partial remainder starts from the numerator's upper bits.
  logic [SUM_W-1:0]  rem;
  logic [PROB_W-1:0] low;
  logic [SUM_W-1:0]  dvs;
  logic [PROB_W-1:0] quot;
  logic [STEP_W-1:0] step;
  logic              busy;

  logic [SUM_W-1:0]  rem_next;
  logic [PROB_W-1:0] low_next;
  logic [PROB_W-1:0] quot_next;

  always_comb begin
    logic [SUM_W:0] trial;
    rem_next  = rem;
    low_next  = low;
    quot_next = quot;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      trial    = {rem_next, low_next[PROB_W-1]};
      low_next = {low_next[PROB_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next  = SUM_W'(trial - {1'b0, dvs});
        quot_next = {quot_next[PROB_W-2:0], 1'b1};
      end else begin
        rem_next  = trial[SUM_W-1:0];
        quot_next = {quot_next[PROB_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (rsp.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.num[NUM_W-1:PROB_W]};
      low  <= req.num[PROB_W-1:0];
      dvs  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      low  <= low_next;
      quot <= quot_next;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = busy && (step == STEP_W'(DIV_STEPS - 1));
  assign rsp.quot = quot;

endmodule

[hdl/adaptive_bit_count_table.sv]
// Adaptive bit count table.
// Input items arrive on the s_ stream: s_tuser is the command (predict or
// learn), s_tdata carries the context in bits 31:0 and the observed bit in
// bit 32. The low 16 context bits pick one pair of zero and one counts.
// A predict item yields one output item on the m_ stream, the probability of
// a one bit scaled by 4095 in m_tdata[11:0]; a learn item yields nothing and
// updates the pair in place.
// The rescale limit is written over the cfg_ channel, which is always ready;
// write it only while no item is in flight.
// After reset the block sweeps the count memory, one entry per cycle, setting
// every count to one. s_tready stays low until that pass ends. The rescale
// limit returns to 1023 at reset.
// Items are handled one at a time around the single count memory, whose read
// is registered. A learn item is read, then modified and written back, before
// the next acceptance. A predict item is read, then passes through the
// iterative divider at three quotient bits per cycle, then the result moves
// into the output register. The output register parts the two sides, so a
// new item is accepted while a result waits; if the receiver still holds
// m_tready low when the next result is ready, the block waits with that
// result until the output register frees up.
module adaptive_bit_count_table import abt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // ctx[31:0], bit_req[32], zero fill
  input  logic                  s_tuser,   // cmd[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // probability[11:0], zero fill
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [TABLE_BITS-1:0] clr_addr;
  logic [TABLE_BITS-1:0] idx;
  logic                  cmd;
  logic                  bit_obs;
  logic                  sum_zero;
  logic [COUNT_W-1:0]    rescale_limit;
  logic [PROB_W-1:0]     out_prob;

  logic                  s_accept;
  logic                  out_free;
  logic                  clearing;

  logic                  ram_we;
  logic [TABLE_BITS-1:0] ram_waddr;
  entry_t                ram_wdata;
  logic                  ram_re;
  entry_t                ram_rdata;

  entry_t                learn_entry;
  logic [SUM_W-1:0]      pair_sum;
  logic [PROB_W-1:0]     prob_clamped;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign clearing  = (state == ST_CLEAR);
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // The count memory holds one pair per entry, zero count in the low half.
  abt_ram #(
    .ADDR_W (TABLE_BITS),
    .DATA_W ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (s_tdata[TABLE_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // The read is launched at acceptance, so the pair is ready in ST_LOOKUP.
  // The learn write-back happens in ST_LOOKUP and the next read cannot be
  // launched before ST_IDLE, so the same entry is never read while in flight.
  assign ram_re    = s_accept;
  assign ram_we    = clearing || (state == ST_LOOKUP && cmd == CMD_LEARN);
  assign ram_waddr = clearing ? clr_addr : idx;
  assign ram_wdata = clearing ? '{one_count: COUNT_ONE, zero_count: COUNT_ONE}
                              : learn_entry;

  assign pair_sum = {1'b0, ram_rdata.zero_count} + {1'b0, ram_rdata.one_count};

  // Learn update: bump the observed count with saturation, then halve both
  // counts, rounding up, once the pair outgrows the limit.
  always_comb begin
    logic [COUNT_W-1:0] zc;
    logic [COUNT_W-1:0] oc;
    logic [SUM_W-1:0]   new_sum;
    logic [SUM_W-1:0]   zc_half;
    logic [SUM_W-1:0]   oc_half;
    zc = ram_rdata.zero_count;
    oc = ram_rdata.one_count;
    if (bit_obs) begin
      if (oc != COUNT_MAX) begin
        oc = oc + COUNT_ONE;
      end
    end else begin
      if (zc != COUNT_MAX) begin
        zc = zc + COUNT_ONE;
      end
    end
    new_sum = {1'b0, zc} + {1'b0, oc};
    zc_half = ({1'b0, zc} + SUM_W'(1)) >> 1;
    oc_half = ({1'b0, oc} + SUM_W'(1)) >> 1;
    if (new_sum > {1'b0, rescale_limit}) begin
      zc = zc_half[COUNT_W-1:0];
      oc = oc_half[COUNT_W-1:0];
    end
    learn_entry.zero_count = zc;
    learn_entry.one_count  = oc;
  end

  // The divider takes ones * 4095 over the pair sum.
  assign div_req.start = (state == ST_LOOKUP) && (cmd == CMD_PREDICT);
  assign div_req.num   = {{PROB_W{1'b0}}, ram_rdata.one_count}
                       * {{COUNT_W{1'b0}}, PROB_SCALE};
  assign div_req.den   = pair_sum;

  abt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // An empty pair cannot occur, but it would read as even odds.
  always_comb begin
    if (sum_zero) begin
      prob_clamped = PROB_MID;
    end else if (div_rsp.quot < PROB_MIN) begin
      prob_clamped = PROB_MIN;
    end else if (div_rsp.quot > PROB_MAX) begin
      prob_clamped = PROB_MAX;
    end else begin
      prob_clamped = div_rsp.quot;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = (cmd == CMD_LEARN) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      rescale_limit <= LIMIT_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + TABLE_BITS'(1);
      end
      if (cfg_valid && cfg_ready) begin
        rescale_limit <= cfg_data;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      idx     <= s_tdata[TABLE_BITS-1:0];
      cmd     <= s_tuser;
      bit_obs <= s_tdata[CTX_W];
    end
    if (state == ST_LOOKUP) begin
      sum_zero <= (pair_sum == '0);
    end
    if (state == ST_OUT && out_free) begin
      out_prob <= prob_clamped;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - PROB_W){1'b0}}, out_prob};

  // An accepted item always goes straight to the memory lookup.
  assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == ST_LOOKUP))
    else $error("accepted item did not reach lookup");

  // The divider is never restarted while it is still iterating.
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The memory port never reads and writes in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("count memory read and write overlap");

  // Every delivered probability lies within the clamped range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_prob >= PROB_MIN && out_prob <= PROB_MAX))
    else $error("probability out of range");

endmodule

[tb/sv/adaptive_bit_count_table_test.sv]
// Checks the adaptive bit count table against a shadow copy of its count
// memory that is kept inside this module.
// Every accepted input item is applied to the shadow table at the moment of
// acceptance. A predict item pushes the probability it must produce onto a
// queue, and a learn item updates the shadow counts in place. A separate
// process drains the output stream and compares each probability with the
// oldest queued one.
module adaptive_bit_count_table_test;
  import abt_pkg::*;

  localparam int          TABLE_DEPTH = 1 << TABLE_BITS;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Enough quiet cycles after the last result for any learn item still in
  // flight to finish its write-back.
  localparam int          SETTLE_CYCLES = 16;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // ctx[31:0], bit_req[32], zero fill
  logic                  s_tuser;   // cmd[0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // probability[11:0], zero fill
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;

  // Shadow of the count memory and of the rescale limit register.
  logic [COUNT_W-1:0] zero_tally [TABLE_DEPTH];
  logic [COUNT_W-1:0] one_tally  [TABLE_DEPTH];
  logic [COUNT_W-1:0] limit_shadow;

  // Probabilities that the block still owes, oldest first.
  logic [PROB_W-1:0] prob_pending [$];

  // Knobs that the stimulus sets for itself and for the output process.
  bit src_idle_en;
  bit snk_idle_en;
  int hold_request;

  int          err_cnt;
  int          n_predict;
  int          n_learn;
  int          n_checked;
  int          n_halved;
  int          n_clamped;
  int unsigned cycle_cnt;

  adaptive_bit_count_table u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is bounded here. The slowest correct run, with the clearing pass
  // after reset, every item waiting out the longest gaps and the long hold-off,
  // stays well below this count.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_cnt, prob_pending.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Probability of a one bit for one entry of the shadow table, scaled by
  // 4095 and kept inside the legal range.
  function automatic logic [PROB_W-1:0] entry_probability(logic [TABLE_BITS-1:0] idx);
    logic [31:0] zc;
    logic [31:0] oc;
    logic [31:0] total;
    logic [31:0] ratio;
    zc    = zero_tally[idx];
    oc    = one_tally[idx];
    total = zc + oc;
    // Counts never fall to zero, but an empty pair would sit in the middle.
    if (total == 0) begin
      return PROB_MID;
    end
    ratio = (oc * PROB_SCALE) / total;
    if (ratio < PROB_MIN) begin
      ratio = PROB_MIN;
      n_clamped++;
    end
    if (ratio > PROB_MAX) begin
      ratio = PROB_MAX;
      n_clamped++;
    end
    return ratio[PROB_W-1:0];
  endfunction

  // Counts one observed bit into an entry. When the pair then sums above the
  // limit both counts are halved once, rounding up, even if the sum is still
  // above the limit afterwards.
  function automatic void entry_learn(logic [TABLE_BITS-1:0] idx, logic seen);
    logic [31:0] zc;
    logic [31:0] oc;
    zc = zero_tally[idx];
    oc = one_tally[idx];
    if (seen) begin
      if (oc < COUNT_MAX) oc = oc + 1;
    end else begin
      if (zc < COUNT_MAX) zc = zc + 1;
    end
    if (zc + oc > limit_shadow) begin
      zc = (zc + 1) >> 1;
      oc = (oc + 1) >> 1;
      n_halved++;
    end
    zero_tally[idx] = zc[COUNT_W-1:0];
    one_tally[idx]  = oc[COUNT_W-1:0];
  endfunction

  // Offers one item and waits until the block takes it. An optional random
  // gap with tvalid low comes first. The shadow table is updated at the edge
  // of acceptance, so the expected results follow the order of acceptance.
  task automatic send_item(logic cmd, logic [CTX_W-1:0] ctx, logic seen);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(IN_DATA_W - CTX_W - 1){1'b0}}, seen, ctx};
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_PREDICT) begin
      prob_pending.push_back(entry_probability(ctx[TABLE_BITS-1:0]));
      n_predict++;
    end else begin
      entry_learn(ctx[TABLE_BITS-1:0], seen);
      n_learn++;
    end
  endtask

  // Stops offering items and waits until every owed result has come back,
  // then gives a trailing learn item time to finish its write-back.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (prob_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the rescale limit. Callers make sure the block is idle first.
  task automatic write_limit(logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    limit_shadow  = value;
  endtask

  // Fresh entries after reset and their first learn updates, with the limit still at its reset value.
  // Both extreme contexts are used, context bits above the index are varied
  // to show they are ignored, and predict items carry either observed bit.
  task automatic test_reset_defaults();
    send_item(CMD_PREDICT, 32'h0000_0000, 1'b0);
    send_item(CMD_PREDICT, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_LEARN,   32'h0000_0000, 1'b1);
    send_item(CMD_PREDICT, 32'h0001_0000, 1'b0);
    send_item(CMD_LEARN,   32'hFFFF_FFFF, 1'b0);
    send_item(CMD_LEARN,   32'h0000_FFFF, 1'b0);
    send_item(CMD_PREDICT, 32'h8000_FFFF, 1'b1);
    send_item(CMD_LEARN,   32'hDEAD_0000, 1'b1);
    send_item(CMD_PREDICT, 32'h0000_0000, 1'b1);
  endtask

  // Halving at the smallest limits, including the case where the sum is
  // still above the limit after one halving.
  task automatic test_halving();
    settle_block();
    write_limit(16'd2);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b0);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
    send_item(CMD_LEARN,   32'h7700_0005, 1'b1);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
    settle_block();
    write_limit(16'd3);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b1);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b1);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b0);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b1);
    settle_block();
    // The pair now sums to three; one more one bit lands above a limit of two
    // even after halving.
    write_limit(16'd2);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b1);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
    send_item(CMD_LEARN,   32'h0000_0005, 1'b0);
    send_item(CMD_PREDICT, 32'h0000_0005, 1'b0);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the output register fills and the block has to stall its input.
  task automatic test_backpressure();
    logic [CTX_W-1:0] ctx;
    int               k;
    settle_block();
    write_limit(LIMIT_RESET);
    src_idle_en  = 1'b0;
    hold_request = 600;
    for (k = 0; k < 50; k++) begin
      ctx = $urandom;
      ctx[TABLE_BITS-1:0] = TABLE_BITS'($urandom_range(0, 3));
      send_item($urandom_range(0, 9) < 7 ? CMD_PREDICT : CMD_LEARN, ctx,
                1'($urandom_range(0, 1)));
    end
    src_idle_en = 1'b1;
  endtask

  // One random phase under one limit. Most items hit a handful of hot entries
  // with random upper context bits, each entry with its own bias toward ones,
  // so counts build up and rescale. The rest are items on random contexts.
  task automatic run_random_phase(int n_items, logic [COUNT_W-1:0] limit);
    logic [TABLE_BITS-1:0] hot_idx [6];
    int                    bias    [6];
    logic [CTX_W-1:0]      ctx;
    logic                  cmd;
    logic                  seen;
    int                    pick;
    int                    k;
    settle_block();
    write_limit(limit);
    for (k = 0; k < 6; k++) begin
      hot_idx[k] = TABLE_BITS'($urandom);
      bias[k]    = $urandom_range(0, 100);
    end
    hot_idx[0] = '0;
    hot_idx[5] = '1;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, 5);
        ctx  = $urandom;
        ctx[TABLE_BITS-1:0] = hot_idx[pick];
        cmd  = ($urandom_range(0, 99) < 60) ? CMD_LEARN : CMD_PREDICT;
        seen = ($urandom_range(0, 99) < bias[pick]);
      end else begin
        ctx  = $urandom;
        cmd  = 1'($urandom_range(0, 1));
        seen = 1'($urandom_range(0, 1));
      end
      send_item(cmd, ctx, seen);
    end
  endtask

  // Random phases over limits from the smallest to the largest. The last phase runs
  // with no idling on either side.
  task automatic test_random();
    run_random_phase(245, COUNT_W'($urandom_range(2, 6)));
    run_random_phase(245, COUNT_W'($urandom_range(7, 64)));
    run_random_phase(245, LIMIT_RESET);
    run_random_phase(245, COUNT_W'($urandom_range(65, 65534)));
    run_random_phase(245, COUNT_MAX);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    run_random_phase(245, 16'd2);
  endtask

  // Output side: checks every accepted probability and picks the next value
  // of m_tready: high, or low for a random stall burst or a long hold-off on request.
  initial begin : result_sink
    logic [PROB_W-1:0] want;
    int                stall_left;
    int                hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_tready  <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (prob_pending.size() == 0) begin
          $error("probability arrived with none expected: actual %0d",
                 m_tdata[PROB_W-1:0]);
          err_cnt++;
        end else begin
          want = prob_pending.pop_front();
          n_checked++;
          if (m_tdata[PROB_W-1:0] !== want) begin
            $error("probability mismatch: expected %0d actual %0d",
                   want, m_tdata[PROB_W-1:0]);
            err_cnt++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      zero_tally[i] = COUNT_ONE;
      one_tally[i]  = COUNT_ONE;
    end
    limit_shadow = LIMIT_RESET;
    err_cnt      = 0;
    n_predict    = 0;
    n_learn      = 0;
    n_checked    = 0;
    n_halved     = 0;
    n_clamped    = 0;
    hold_request = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_PREDICT;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The block clears its memory after reset; send_item simply waits on
    // s_tready until that pass is over.
    test_reset_defaults();
    test_halving();
    test_backpressure();
    test_random();
    settle_block();

    if (prob_pending.size() != 0) begin
      $error("%0d probabilities never arrived", prob_pending.size());
      err_cnt++;
    end
    $display("Run covered %0d predict and %0d learn items in %0d cycles, %0d results checked.",
             n_predict, n_learn, cycle_cnt, n_checked);
    $display("Limits from 2 to 65535 were used; %0d halvings and %0d clamped results expected.",
             n_halved, n_clamped);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/abt_pkg.sv
hdl/abt_ram.sv
hdl/abt_div.sv
hdl/adaptive_bit_count_table.sv
tb/sv/adaptive_bit_count_table_test.sv
